FILE: rtl/fghc_pkg.sv
// Shared types, constants and codes for the fan gear hysteresis controller.
// No dependencies; every other file refers to it by scoped names.
package fghc_pkg;

  localparam int CODE_W     = 12;
  localparam int CMD_W      = 2;
  localparam int GEAR_W     = 2;
  localparam int TIMEOUT_W  = 16;
  localparam int IDLE_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int SAMPLES_LOG2_DEFAULT = 4;

  localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WAKE   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RISE_ONE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_TWO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_THREE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_ZERO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_ONE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_TWO   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TMO   = 3'd6;

  localparam logic [CODE_W-1:0]    RST_RISE_ONE   = 12'd3153;
  localparam logic [CODE_W-1:0]    RST_RISE_TWO   = 12'd3058;
  localparam logic [CODE_W-1:0]    RST_RISE_THREE = 12'd2958;
  localparam logic [CODE_W-1:0]    RST_FALL_ZERO  = 12'd3184;
  localparam logic [CODE_W-1:0]    RST_FALL_ONE   = 12'd3090;
  localparam logic [CODE_W-1:0]    RST_FALL_TWO   = 12'd2991;
  localparam logic [TIMEOUT_W-1:0] RST_IDLE_TMO   = 16'd10000;

  localparam logic [GEAR_W-1:0] GEAR_OFF   = 2'd0;
  localparam logic [GEAR_W-1:0] GEAR_ONE   = 2'd1;
  localparam logic [GEAR_W-1:0] GEAR_TWO   = 2'd2;
  localparam logic [GEAR_W-1:0] GEAR_THREE = 2'd3;

  typedef struct packed {
    logic [CODE_W-1:0]    rise_one;
    logic [CODE_W-1:0]    rise_two;
    logic [CODE_W-1:0]    rise_three;
    logic [CODE_W-1:0]    fall_zero;
    logic [CODE_W-1:0]    fall_one;
    logic [CODE_W-1:0]    fall_two;
    logic [TIMEOUT_W-1:0] idle_timeout;
  } cfg_t;

  typedef struct packed {
    logic [GEAR_W-1:0] gear;
    logic              gear_changed;
    logic              sleep_request;
    logic [CODE_W-1:0] average_code;
  } out_item_t;

endpackage

FILE: rtl/fghc_if.sv
// Valid/ready channel interfaces: sample/command input, result output, register writes.
// Depends on fghc_pkg for field widths.
interface fghc_in_if;
  logic                       valid;
  logic                       ready;
  logic [fghc_pkg::CMD_W-1:0]  command;
  logic [fghc_pkg::CODE_W-1:0] sample_code;
  modport source (output valid, command, sample_code, input ready);
  modport sink   (input valid, command, sample_code, output ready);
endinterface

interface fghc_out_if;
  logic                       valid;
  logic                       ready;
  logic [fghc_pkg::GEAR_W-1:0] gear;
  logic                       gear_changed;
  logic                       sleep_request;
  logic [fghc_pkg::CODE_W-1:0] average_code;
  modport source (output valid, gear, gear_changed, sleep_request, average_code, input ready);
  modport sink   (input valid, gear, gear_changed, sleep_request, average_code, output ready);
endinterface

interface fghc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fghc_pkg::CFG_IDX_W-1:0]  index;
  logic [fghc_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/fghc_cfg_regs.sv
// Threshold and timeout register file, written through the configuration channel.
// Depends on fghc_pkg.
module fghc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [fghc_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [fghc_pkg::CFG_DATA_W-1:0] wr_data,
  output fghc_pkg::cfg_t                  cfg
);

  fghc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rise_one     <= fghc_pkg::RST_RISE_ONE;
      cfg_r.rise_two     <= fghc_pkg::RST_RISE_TWO;
      cfg_r.rise_three   <= fghc_pkg::RST_RISE_THREE;
      cfg_r.fall_zero    <= fghc_pkg::RST_FALL_ZERO;
      cfg_r.fall_one     <= fghc_pkg::RST_FALL_ONE;
      cfg_r.fall_two     <= fghc_pkg::RST_FALL_TWO;
      cfg_r.idle_timeout <= fghc_pkg::RST_IDLE_TMO;
    end else if (wr_en) begin
      case (wr_index)
        fghc_pkg::REG_RISE_ONE:   cfg_r.rise_one     <= wr_data[fghc_pkg::CODE_W-1:0];
        fghc_pkg::REG_RISE_TWO:   cfg_r.rise_two     <= wr_data[fghc_pkg::CODE_W-1:0];
        fghc_pkg::REG_RISE_THREE: cfg_r.rise_three   <= wr_data[fghc_pkg::CODE_W-1:0];
        fghc_pkg::REG_FALL_ZERO:  cfg_r.fall_zero    <= wr_data[fghc_pkg::CODE_W-1:0];
        fghc_pkg::REG_FALL_ONE:   cfg_r.fall_one     <= wr_data[fghc_pkg::CODE_W-1:0];
        fghc_pkg::REG_FALL_TWO:   cfg_r.fall_two     <= wr_data[fghc_pkg::CODE_W-1:0];
        fghc_pkg::REG_IDLE_TMO:   cfg_r.idle_timeout <= wr_data[fghc_pkg::TIMEOUT_W-1:0];
        default: ; // index past the register list: write dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/fghc_core.sv
// Sample accumulation, gear hysteresis step and idle tick counter.
// Depends on fghc_pkg; produces at most one result per accepted beat.
module fghc_core #(
  parameter int SAMPLES_LOG2 = fghc_pkg::SAMPLES_LOG2_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [fghc_pkg::CMD_W-1:0]    command,
  input  logic [fghc_pkg::CODE_W-1:0]   sample_code,
  input  fghc_pkg::cfg_t                cfg,
  output logic                          res_valid,
  output fghc_pkg::out_item_t           res_item
);

  localparam int SUM_W = fghc_pkg::CODE_W + SAMPLES_LOG2;
  localparam int CNT_W = (SAMPLES_LOG2 == 0) ? 1 : SAMPLES_LOG2;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'((1 << SAMPLES_LOG2) - 1);

  logic [SUM_W-1:0]                sum_r, sum_nxt, sum_add;
  logic [CNT_W-1:0]                cnt_r, cnt_nxt;
  logic [fghc_pkg::GEAR_W-1:0]     gear_r, gear_nxt, gear_eval;
  logic [fghc_pkg::IDLE_W-1:0]     idle_r, idle_nxt;
  logic [fghc_pkg::CODE_W-1:0]     avg;
  logic                            is_sample, group_done;

  assign is_sample  = accept && (command == fghc_pkg::CMD_SAMPLE);
  assign group_done = is_sample && (cnt_r == CNT_LAST);
  assign sum_add    = sum_r + SUM_W'(sample_code);
  assign avg        = sum_add[SAMPLES_LOG2 +: fghc_pkg::CODE_W];

  // Hotter sensor = lower code. Rise test wins over fall test.
  always_comb begin
    gear_eval = gear_r;
    case (gear_r)
      fghc_pkg::GEAR_OFF: begin
        if (avg <= cfg.rise_one) gear_eval = fghc_pkg::GEAR_ONE;
      end
      fghc_pkg::GEAR_ONE: begin
        if (avg <= cfg.rise_two)      gear_eval = fghc_pkg::GEAR_TWO;
        else if (avg > cfg.fall_zero) gear_eval = fghc_pkg::GEAR_OFF;
      end
      fghc_pkg::GEAR_TWO: begin
        if (avg <= cfg.rise_three)   gear_eval = fghc_pkg::GEAR_THREE;
        else if (avg > cfg.fall_one) gear_eval = fghc_pkg::GEAR_ONE;
      end
      default: begin
        if (avg > cfg.fall_two) gear_eval = fghc_pkg::GEAR_TWO;
      end
    endcase
  end

  always_comb begin
    sum_nxt  = sum_r;
    cnt_nxt  = cnt_r;
    gear_nxt = gear_r;
    idle_nxt = idle_r;
    if (accept) begin
      case (command)
        fghc_pkg::CMD_SAMPLE: begin
          if (group_done) begin
            sum_nxt  = '0;
            cnt_nxt  = '0;
            gear_nxt = gear_eval;
            if (gear_eval != gear_r && gear_eval == fghc_pkg::GEAR_OFF) idle_nxt = '0;
          end else begin
            sum_nxt = sum_add;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        fghc_pkg::CMD_TICK: begin
          if (idle_r != fghc_pkg::IDLE_MAX) idle_nxt = idle_r + 1'b1;
        end
        fghc_pkg::CMD_WAKE: idle_nxt = '0;
        default: ; // unused command
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      cnt_r  <= '0;
      gear_r <= fghc_pkg::GEAR_OFF;
      idle_r <= '0;
    end else begin
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
      gear_r <= gear_nxt;
      idle_r <= idle_nxt;
    end
  end

  assign res_valid              = group_done;
  assign res_item.gear          = gear_eval;
  assign res_item.gear_changed  = (gear_eval != gear_r);
  assign res_item.sleep_request = (gear_eval == fghc_pkg::GEAR_OFF) &&
                                  (idle_nxt > fghc_pkg::IDLE_W'(cfg.idle_timeout));
  assign res_item.average_code  = avg;

  // gear moves one step at a time
  a_gear_step: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, gear_r} == {1'b0, $past(gear_r)}) ||
    ({1'b0, gear_r} == {1'b0, $past(gear_r)} + 3'd1) ||
    ({1'b0, gear_r} + 3'd1 == {1'b0, $past(gear_r)}))
    else $error("gear jumped more than one step");

  // gear only changes on a completed sample group
  a_gear_on_group: assert property (@(posedge clk) disable iff (!rst_n)
    !group_done |=> gear_r == $past(gear_r))
    else $error("gear changed outside an evaluation");

  // group bookkeeping restarts after an evaluation
  a_group_restart: assert property (@(posedge clk) disable iff (!rst_n)
    group_done |=> (cnt_r == '0) && (sum_r == '0))
    else $error("sample group not cleared after evaluation");

endmodule

FILE: rtl/fghc_out_buf.sv
// Two-entry result buffer: output register plus skid slot, so input keeps flowing
// while a result waits. Depends on fghc_pkg.
module fghc_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fghc_pkg::out_item_t push_item,
  output logic                has_room,
  output logic                out_valid,
  input  logic                out_ready,
  output fghc_pkg::out_item_t out_item
);

  logic                v0_r, v1_r;
  fghc_pkg::out_item_t d0_r, d1_r;
  logic                pop;

  assign pop      = v0_r && out_ready;
  assign has_room = !v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (!v0_r || pop) begin
      if (v1_r) begin
        v0_r <= 1'b1;
        v1_r <= push;
      end else begin
        v0_r <= push;
        v1_r <= 1'b0;
      end
    end else if (push) begin
      v1_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!v0_r || pop) begin
      if (v1_r) begin
        d0_r <= d1_r;
        if (push) d1_r <= push_item;
      end else if (push) begin
        d0_r <= push_item;
      end
    end else if (push) begin
      d1_r <= push_item;
    end
  end

  assign out_valid = v0_r;
  assign out_item  = d0_r;

  // skid slot is only used behind a held head
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> v0_r)
    else $error("skid slot filled with empty head");

  // a stalled head keeps its beat
  a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v0_r && !out_ready) |=> v0_r && (d0_r == $past(d0_r)))
    else $error("stalled result lost");

  // no result arrives while both slots are taken
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !v1_r)
    else $error("result pushed into a full buffer");

endmodule

FILE: rtl/fan_gear_hysteresis_controller.sv
// Channel  | dir | beat contents                                | handshake
// in_ch    | in  | command, sample_code                         | valid/ready
// out_ch   | out | gear, gear_changed, sleep_request, average_code | valid/ready
// cfg_ch   | in  | index (register number), data                | valid/ready, ready high
//
// One beat per clock on the input while the result buffer has room; a result is computed when the
// 2^SAMPLES_LOG2-th sample of a group is accepted and is registered into the result buffer.
// Synchronous active-low reset clears group, gear, idle counter and loads default thresholds.
// A two-entry result buffer keeps in_ch.ready high until two results are stalled.
// Ticks and wake beats produce no result.
module fan_gear_hysteresis_controller #(
  parameter int SAMPLES_LOG2 = fghc_pkg::SAMPLES_LOG2_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  fghc_in_if.sink     in_ch,
  fghc_out_if.source  out_ch,
  fghc_cfg_if.sink    cfg_ch
);

  fghc_pkg::cfg_t      cfg;
  fghc_pkg::out_item_t res_item, head_item;
  logic                res_valid, has_room, accept;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = has_room;
  assign accept       = in_ch.valid && has_room;

  fghc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  fghc_core #(.SAMPLES_LOG2(SAMPLES_LOG2)) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .command     (in_ch.command),
    .sample_code (in_ch.sample_code),
    .cfg         (cfg),
    .res_valid   (res_valid),
    .res_item    (res_item)
  );

  fghc_out_buf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_item (res_item),
    .has_room  (has_room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (head_item)
  );

  assign out_ch.gear          = head_item.gear;
  assign out_ch.gear_changed  = head_item.gear_changed;
  assign out_ch.sleep_request = head_item.sleep_request;
  assign out_ch.average_code  = head_item.average_code;

endmodule

FILE: bench/tb_fan_gear_hysteresis_controller.sv
// Self-checking bench for fan_gear_hysteresis_controller: directed table, then random phases.
// Needs fghc_pkg and the fghc_*_if interfaces; results are checked against table values or an in-bench predictor.
module tb_fan_gear_hysteresis_controller;

  localparam int GROUP_LOG2 = fghc_pkg::SAMPLES_LOG2_DEFAULT;
  localparam int GROUP_SIZE = 1 << GROUP_LOG2;
  localparam logic [fghc_pkg::CMD_W-1:0]     CMD_UNUSED   = 2'd3;
  localparam logic [fghc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;   // no register there

  typedef enum logic {ROW_BEATS, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                        kind;
    logic [fghc_pkg::CFG_IDX_W-1:0]   idx;
    logic [fghc_pkg::CMD_W-1:0]       cmd;
    logic [fghc_pkg::CFG_DATA_W-1:0]  val;
    logic [31:0]                      count;
    logic                             pin;
    fghc_pkg::out_item_t              want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  fghc_in_if  in_ch ();
  fghc_out_if out_ch ();
  fghc_cfg_if cfg_ch ();

  fan_gear_hysteresis_controller #(.SAMPLES_LOG2(GROUP_LOG2)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #6 clk = ~clk;

  // predictor state
  fghc_pkg::cfg_t              cfg_now;
  int unsigned                 group_sum;
  int unsigned                 group_cnt;
  logic [fghc_pkg::GEAR_W-1:0] ctl_gear;
  logic [fghc_pkg::IDLE_W-1:0] idle_ticks;

  fghc_pkg::out_item_t pending_results[$];
  dir_row_t            dir_rows[$];
  int                  mismatches;
  int                  beats_sent;
  int                  results_made;
  bit                  quiet_in;
  bit                  quiet_out;

  function automatic logic [fghc_pkg::GEAR_W-1:0] gear_step(
      input logic [fghc_pkg::CODE_W-1:0] avg,
      input logic [fghc_pkg::GEAR_W-1:0] g);
    case (g)
      fghc_pkg::GEAR_OFF: begin
        if (avg <= cfg_now.rise_one) return fghc_pkg::GEAR_ONE;
      end
      fghc_pkg::GEAR_ONE: begin
        if (avg <= cfg_now.rise_two) return fghc_pkg::GEAR_TWO;
        if (avg > cfg_now.fall_zero) return fghc_pkg::GEAR_OFF;
      end
      fghc_pkg::GEAR_TWO: begin
        if (avg <= cfg_now.rise_three) return fghc_pkg::GEAR_THREE;
        if (avg > cfg_now.fall_one) return fghc_pkg::GEAR_ONE;
      end
      default: begin
        if (avg > cfg_now.fall_two) return fghc_pkg::GEAR_TWO;
      end
    endcase
    return g;
  endfunction

  function automatic bit step_controller(input logic [fghc_pkg::CMD_W-1:0] cmd,
                                         input logic [fghc_pkg::CODE_W-1:0] code,
                                         output fghc_pkg::out_item_t res);
    logic [fghc_pkg::CODE_W-1:0] avg;
    logic [fghc_pkg::GEAR_W-1:0] prev;
    res = '0;
    case (cmd)
      fghc_pkg::CMD_TICK: begin
        if (idle_ticks != fghc_pkg::IDLE_MAX) idle_ticks = idle_ticks + 1'b1;
        return 1'b0;
      end
      fghc_pkg::CMD_WAKE: begin
        idle_ticks = '0;
        return 1'b0;
      end
      fghc_pkg::CMD_SAMPLE: begin
        group_sum = group_sum + code;
        group_cnt = group_cnt + 1;
        if (group_cnt < GROUP_SIZE) return 1'b0;
        avg = fghc_pkg::CODE_W'(group_sum >> GROUP_LOG2);
        group_sum = 0;
        group_cnt = 0;
        prev = ctl_gear;
        ctl_gear = gear_step(avg, prev);
        // falling back to off restarts the idle count before sleep is judged
        if (ctl_gear != prev && ctl_gear == fghc_pkg::GEAR_OFF) idle_ticks = '0;
        res.gear          = ctl_gear;
        res.gear_changed  = (ctl_gear != prev);
        res.sleep_request = (ctl_gear == fghc_pkg::GEAR_OFF) &&
                            (idle_ticks > cfg_now.idle_timeout);
        res.average_code  = avg;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic send_beat(input logic [fghc_pkg::CMD_W-1:0] cmd,
                           input logic [fghc_pkg::CODE_W-1:0] code,
                           input bit pin, input fghc_pkg::out_item_t want);
    int gap;
    fghc_pkg::out_item_t res;
    gap = quiet_in ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.sample_code <= code;
    do @(posedge clk); while (!in_ch.ready);
    if (step_controller(cmd, code, res)) begin
      pending_results.push_back(pin ? want : res);
      results_made++;
    end
    if (cmd != CMD_UNUSED) beats_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [fghc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fghc_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      fghc_pkg::REG_RISE_ONE:   cfg_now.rise_one     = data[fghc_pkg::CODE_W-1:0];
      fghc_pkg::REG_RISE_TWO:   cfg_now.rise_two     = data[fghc_pkg::CODE_W-1:0];
      fghc_pkg::REG_RISE_THREE: cfg_now.rise_three   = data[fghc_pkg::CODE_W-1:0];
      fghc_pkg::REG_FALL_ZERO:  cfg_now.fall_zero    = data[fghc_pkg::CODE_W-1:0];
      fghc_pkg::REG_FALL_ONE:   cfg_now.fall_one     = data[fghc_pkg::CODE_W-1:0];
      fghc_pkg::REG_FALL_TWO:   cfg_now.fall_two     = data[fghc_pkg::CODE_W-1:0];
      fghc_pkg::REG_IDLE_TMO:   cfg_now.idle_timeout = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // wait for every result, then let a trailing tick or wake beat settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic void add_beats(input logic [fghc_pkg::CMD_W-1:0] cmd,
                                    input logic [fghc_pkg::CODE_W-1:0] code,
                                    input int count);
    dir_row_t r;
    r = '0;
    r.kind  = ROW_BEATS;
    r.cmd   = cmd;
    r.val   = code;
    r.count = count;
    dir_rows.push_back(r);
  endfunction

  // a full group of one code, so the average equals the code
  function automatic void add_group(input logic [fghc_pkg::CODE_W-1:0] code,
                                    input logic [fghc_pkg::GEAR_W-1:0] g,
                                    input logic chg, input logic slp);
    dir_row_t r;
    r = '0;
    r.kind  = ROW_BEATS;
    r.cmd   = fghc_pkg::CMD_SAMPLE;
    r.val   = code;
    r.count = GROUP_SIZE;
    r.pin   = 1'b1;
    r.want  = {g, chg, slp, code};
    dir_rows.push_back(r);
  endfunction

  function automatic void add_write(input logic [fghc_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [fghc_pkg::CFG_DATA_W-1:0] data);
    dir_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.idx  = idx;
    r.val  = data;
    dir_rows.push_back(r);
  endfunction

  initial begin : result_sink
    int stall;
    fghc_pkg::out_item_t got;
    fghc_pkg::out_item_t want;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      stall = quiet_out ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got = {out_ch.gear, out_ch.gear_changed, out_ch.sleep_request, out_ch.average_code};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with nothing expected: gear %0d avg %0d",
                   $time, got.gear, got.average_code);
      end else begin
        want = pending_results.pop_front();
        if (got.gear !== want.gear || got.gear_changed !== want.gear_changed ||
            got.sleep_request !== want.sleep_request ||
            got.average_code !== want.average_code) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: mismatch exp/act gear %0d/%0d changed %0b/%0b ",
                      "sleep %0b/%0b avg %0d/%0d"}, $time, want.gear, got.gear,
                     want.gear_changed, got.gear_changed, want.sleep_request,
                     got.sleep_request, want.average_code, got.average_code);
        end
      end
    end
  end

  initial begin
    #(12 * 1_500_000);
    $display("tb_fan_gear_hysteresis_controller: FAIL");
    $finish;
  end

  initial begin : stimulus
    dir_row_t row;
    logic [fghc_pkg::CFG_DATA_W-1:0] regv [0:fghc_pkg::REG_IDLE_TMO];
    int phase, g, s, k, v, aim, spread, base, stride;
    int start_beats, start_results;
    bit noisy;

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.command      = fghc_pkg::CMD_SAMPLE;
    in_ch.sample_code  = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = fghc_pkg::REG_RISE_ONE;
    cfg_ch.data        = '0;
    quiet_in           = 1'b0;
    quiet_out          = 1'b0;
    mismatches         = 0;
    beats_sent         = 0;
    results_made       = 0;

    cfg_now.rise_one     = fghc_pkg::RST_RISE_ONE;
    cfg_now.rise_two     = fghc_pkg::RST_RISE_TWO;
    cfg_now.rise_three   = fghc_pkg::RST_RISE_THREE;
    cfg_now.fall_zero    = fghc_pkg::RST_FALL_ZERO;
    cfg_now.fall_one     = fghc_pkg::RST_FALL_ONE;
    cfg_now.fall_two     = fghc_pkg::RST_FALL_TWO;
    cfg_now.idle_timeout = fghc_pkg::RST_IDLE_TMO;
    group_sum  = 0;
    group_cnt  = 0;
    ctl_gear   = fghc_pkg::GEAR_OFF;
    idle_ticks = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part, on reset thresholds unless a row rewrites one
    add_group(12'd4095, fghc_pkg::GEAR_OFF,   1'b0, 1'b0);
    add_group(12'd0,    fghc_pkg::GEAR_ONE,   1'b1, 1'b0);   // one step per evaluation
    add_group(12'd0,    fghc_pkg::GEAR_TWO,   1'b1, 1'b0);
    add_group(12'd0,    fghc_pkg::GEAR_THREE, 1'b1, 1'b0);
    add_group(12'd0,    fghc_pkg::GEAR_THREE, 1'b0, 1'b0);
    add_group(12'd4095, fghc_pkg::GEAR_TWO,   1'b1, 1'b0);
    add_group(12'd4095, fghc_pkg::GEAR_ONE,   1'b1, 1'b0);
    add_group(12'd4095, fghc_pkg::GEAR_OFF,   1'b1, 1'b0);
    add_group(fghc_pkg::RST_RISE_ONE, fghc_pkg::GEAR_ONE, 1'b1, 1'b0);    // at threshold rises
    add_group(fghc_pkg::RST_FALL_ZERO, fghc_pkg::GEAR_ONE, 1'b0, 1'b0);   // at threshold holds
    add_group(fghc_pkg::RST_FALL_ZERO + 12'd1, fghc_pkg::GEAR_OFF, 1'b1, 1'b0);
    add_beats(fghc_pkg::CMD_TICK, 12'hfff, 5);
    add_beats(fghc_pkg::CMD_WAKE, 12'h000, 1);
    add_beats(CMD_UNUSED, 12'hfff, 3);
    add_beats(fghc_pkg::CMD_TICK, 12'h555, 3);
    add_write(fghc_pkg::REG_IDLE_TMO, 16'h0000);
    add_group(12'd4095, fghc_pkg::GEAR_OFF, 1'b0, 1'b1);
    add_beats(fghc_pkg::CMD_WAKE, 12'haaa, 1);
    add_group(12'd4095, fghc_pkg::GEAR_OFF, 1'b0, 1'b0);
    add_write(fghc_pkg::REG_IDLE_TMO, 16'hffff);
    add_group(12'd4095, fghc_pkg::GEAR_OFF, 1'b0, 1'b0);
    add_group(12'd0,    fghc_pkg::GEAR_ONE, 1'b1, 1'b0);
    add_beats(fghc_pkg::CMD_TICK, 12'h0f0, 2);
    add_group(12'd4095, fghc_pkg::GEAR_OFF, 1'b1, 1'b0);

    for (int i = 0; i < dir_rows.size(); i++) begin
      row = dir_rows[i];
      if (row.kind == ROW_WRITE) begin
        drain();
        write_reg(row.idx, row.val);
        cfg_ch.valid <= 1'b0;
      end else begin
        quiet_in = (row.count > 1000);
        for (k = 0; k < row.count; k++)
          send_beat(row.cmd, row.val[fghc_pkg::CODE_W-1:0],
                    row.pin && (k == row.count - 1), row.want);
      end
    end
    quiet_in = 1'b0;

    // random phases, each on its own register setting
    start_beats   = beats_sent;
    start_results = results_made;
    for (phase = 0; phase < 4 || beats_sent - start_beats < 450 ||
                    results_made - start_results < 24; phase++) begin
      drain();
      if (phase == 0) begin
        foreach (regv[r]) regv[r] = '0;
      end else if (phase == 1) begin
        foreach (regv[r]) regv[r] = '1;
      end else if ($urandom_range(0, 2) != 0) begin
        // well-ordered hysteresis ladder; hotter means a lower code
        base   = $urandom_range(100, 3800);
        stride = $urandom_range(1, 40);
        regv[fghc_pkg::REG_RISE_THREE] = {4'($urandom_range(0, 15)),
                                          fghc_pkg::CODE_W'(base)};
        regv[fghc_pkg::REG_FALL_TWO]   = {4'($urandom_range(0, 15)),
                                          fghc_pkg::CODE_W'(base + stride)};
        regv[fghc_pkg::REG_RISE_TWO]   = {4'($urandom_range(0, 15)),
                                          fghc_pkg::CODE_W'(base + 2 * stride)};
        regv[fghc_pkg::REG_FALL_ONE]   = {4'($urandom_range(0, 15)),
                                          fghc_pkg::CODE_W'(base + 3 * stride)};
        regv[fghc_pkg::REG_RISE_ONE]   = {4'($urandom_range(0, 15)),
                                          fghc_pkg::CODE_W'(base + 4 * stride)};
        regv[fghc_pkg::REG_FALL_ZERO]  = {4'($urandom_range(0, 15)),
                                          fghc_pkg::CODE_W'(base + 5 * stride)};
      end else begin
        foreach (regv[r]) regv[r] = fghc_pkg::CFG_DATA_W'($urandom);
      end
      if (phase > 1) begin
        case ($urandom_range(0, 4))
          0:       regv[fghc_pkg::REG_IDLE_TMO] = '0;
          1:       regv[fghc_pkg::REG_IDLE_TMO] = '1;
          2:       regv[fghc_pkg::REG_IDLE_TMO] = fghc_pkg::CFG_DATA_W'($urandom);
          default: regv[fghc_pkg::REG_IDLE_TMO] = fghc_pkg::CFG_DATA_W'($urandom_range(1, 40));
        endcase
      end
      foreach (regv[r]) write_reg(fghc_pkg::CFG_IDX_W'(r), regv[r]);
      if (phase == 2) write_reg(REG_UNMAPPED, fghc_pkg::CFG_DATA_W'($urandom));
      cfg_ch.valid <= 1'b0;

      quiet_in  = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);

      for (g = 0; g < 6; g++) begin
        noisy = ($urandom_range(0, 7) == 0);
        // aim the group average at whichever threshold the current gear is tested against
        case (ctl_gear)
          fghc_pkg::GEAR_OFF: aim = cfg_now.rise_one;
          fghc_pkg::GEAR_ONE: aim = $urandom_range(0, 1) ? cfg_now.rise_two : cfg_now.fall_zero;
          fghc_pkg::GEAR_TWO: aim = $urandom_range(0, 1) ? cfg_now.rise_three : cfg_now.fall_one;
          default:            aim = cfg_now.fall_two;
        endcase
        if ($urandom_range(0, 5) == 0) aim = $urandom_range(0, 1) ? 4095 : 0;
        aim    = aim + int'($urandom_range(0, 6)) - 3;
        spread = $urandom_range(0, 8);
        for (s = 0; s < GROUP_SIZE; s++) begin
          while ($urandom_range(0, 3) == 0)
            send_beat(fghc_pkg::CMD_TICK, fghc_pkg::CODE_W'($urandom), 1'b0, '0);
          if ($urandom_range(0, 19) == 0)
            send_beat(fghc_pkg::CMD_WAKE, fghc_pkg::CODE_W'($urandom), 1'b0, '0);
          if ($urandom_range(0, 29) == 0)
            send_beat(CMD_UNUSED, fghc_pkg::CODE_W'($urandom), 1'b0, '0);
          if (noisy) v = $urandom_range(0, 4095);
          else v = aim + int'($urandom_range(0, 2 * spread)) - spread;
          if (v < 0) v = 0;
          if (v > 4095) v = 4095;
          send_beat(fghc_pkg::CMD_SAMPLE, fghc_pkg::CODE_W'(v), 1'b0, '0);
        end
      end
    end

    drain();
    repeat (16) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("tb_fan_gear_hysteresis_controller: PASS");
    else
      $display("tb_fan_gear_hysteresis_controller: FAIL");
    $finish;
  end

endmodule

FILE: files.f
rtl/fghc_pkg.sv
rtl/fghc_if.sv
rtl/fghc_cfg_regs.sv
rtl/fghc_core.sv
rtl/fghc_out_buf.sv
rtl/fan_gear_hysteresis_controller.sv
bench/tb_fan_gear_hysteresis_controller.sv
